### sv/rank_order_of_leading_items_defines.svh
// ----------------------------------------------------------------------------
// Rank order of leading items: assertion macros
// Shared property wrappers for the checker of the ranking block.
// ----------------------------------------------------------------------------
`ifndef RANK_ORDER_OF_LEADING_ITEMS_DEFINES_SVH
`define RANK_ORDER_OF_LEADING_ITEMS_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define ROLI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ROLI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define ROLI_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/roli_pkg.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: package
// Sizes, the queue word format and the report limit helper.
// ----------------------------------------------------------------------------
package roli_pkg;

   // Row storage and field sizes.
   localparam int ROW_ITEMS   = 64;
   localparam int SCORE_W     = 16;
   localparam int IDX_W       = 6;
   localparam int LIM_W       = 7;
   localparam int MAX_REPORT  = 64;
   localparam int SLOT_W      = (ROW_ITEMS > 1) ? $clog2(ROW_ITEMS) : 1;
   localparam int CNT_W       = $clog2(ROW_ITEMS + 1);
   localparam int WIDE_W      = (LIM_W > CNT_W) ? LIM_W : CNT_W;
   localparam int INDEX_LIMIT_RESET = 2;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified word as it travels through the queue.
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      wr;
      logic                      last;
   } entry_type;

   // Number of items reported for a row: the limit, capped at the widest
   // reportable index range and at the number of stored scores.
   function automatic logic [CNT_W-1:0] report_count(input logic [LIM_W-1:0] limit,
                                                     input logic [CNT_W-1:0] stored);
      logic [WIDE_W-1:0] lim_w;
      logic [WIDE_W-1:0] cnt_w;
      lim_w = WIDE_W'(limit);
      cnt_w = WIDE_W'(stored);
      if (lim_w > WIDE_W'(MAX_REPORT)) begin
         lim_w = WIDE_W'(MAX_REPORT);
      end
      if (lim_w > cnt_w) begin
         lim_w = cnt_w;
      end
      return CNT_W'(lim_w);
   endfunction

endpackage

### sv/roli_front.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: front end
// Accepts score words, tracks the row fill and marks words past the row
// capacity as dropped before they enter the queue.
// ----------------------------------------------------------------------------
module roli_front
   import roli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic                      req_row_last,
   input  logic                      q_full,
   output logic                      q_push,
   output entry_type                 q_entry
);

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             accept;

   // The queue being full is the only reason to hold off the sender.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // Classify the word: stored while the row has room, always passed on.
   always_comb begin
      q_entry.score = req_score;
      q_entry.wr    = (fill_ff < CNT_W'(ROW_ITEMS));
      q_entry.last  = req_row_last;
   end

   // Row fill count, cleared when the row ends.
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_row_last) begin
            fill_in = '0;
         end else if (q_entry.wr) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

### sv/roli_queue.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: queue
// Short first-in first-out buffer that lets the front keep taking words
// while the back is busy.
// ----------------------------------------------------------------------------
module roli_queue
   import roli_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] used_ff;
   logic [QCNT_W-1:0] used_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (used_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (used_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      used_in   = used_ff;
      if (do_push && !do_pop) begin
         used_in = used_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   // Storage words need no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/roli_back.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: back end
// While loading, sorted cells take one score per cycle by parallel insertion.
// After the row ends the cells shift out toward the head, and each head
// whose index falls below the report count goes to the result register.
// ----------------------------------------------------------------------------
module roli_back
   import roli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [LIM_W-1:0] index_limit,
   input  logic             q_valid,
   input  entry_type        q_entry,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_item_index,
   output logic             rsp_has_index,
   output logic             rsp_row_done
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                      state_ff;
   logic                      state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          lim_ff;
   logic [CNT_W-1:0]          lim_in;
   logic [CNT_W-1:0]          sent_ff;
   logic [CNT_W-1:0]          sent_in;
   logic                      insert;
   logic                      shift;
   logic                      emit;
   logic                      out_free;
   logic [IDX_W-1:0]          emit_index;
   logic                      emit_has;
   logic                      emit_done;

   logic signed [SCORE_W-1:0] score_ff   [ROW_ITEMS];
   logic signed [SCORE_W-1:0] score_in   [ROW_ITEMS];
   logic [SLOT_W-1:0]         slot_ff    [ROW_ITEMS];
   logic [SLOT_W-1:0]         slot_in    [ROW_ITEMS];
   logic signed [SCORE_W-1:0] prev_score [ROW_ITEMS];
   logic [SLOT_W-1:0]         prev_slot  [ROW_ITEMS];
   logic signed [SCORE_W-1:0] next_score [ROW_ITEMS];
   logic [SLOT_W-1:0]         next_slot  [ROW_ITEMS];
   logic [ROW_ITEMS-1:0]      goes_ahead;
   logic [ROW_ITEMS-1:0]      prev_ahead;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [IDX_W-1:0]          rsp_index_ff;
   logic                      rsp_has_ff;
   logic                      rsp_done_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Neighbor taps of each cell.
   for (genvar g = 0; g < ROW_ITEMS; g++) begin : g_tap
      if (g == 0) begin : g_head
         assign prev_score[g] = score_ff[g];
         assign prev_slot[g]  = slot_ff[g];
      end else begin : g_body
         assign prev_score[g] = score_ff[g-1];
         assign prev_slot[g]  = slot_ff[g-1];
      end
      if (g == ROW_ITEMS - 1) begin : g_tail
         assign next_score[g] = score_ff[g];
         assign next_slot[g]  = slot_ff[g];
      end else begin : g_inner
         assign next_score[g] = score_ff[g+1];
         assign next_slot[g]  = slot_ff[g+1];
      end
   end

   // The new score goes ahead of an empty cell and of any strictly lower
   // score; equal scores stay ahead since they came earlier in the row.
   always_comb begin
      for (int i = 0; i < ROW_ITEMS; i++) begin
         goes_ahead[i] = (CNT_W'(i) >= count_ff) || (q_entry.score > score_ff[i]);
      end
      prev_ahead = {goes_ahead[ROW_ITEMS-2:0], 1'b0};
   end

   // Cell update: insert, shift toward the head, or hold.
   always_comb begin
      for (int i = 0; i < ROW_ITEMS; i++) begin
         score_in[i] = score_ff[i];
         slot_in[i]  = slot_ff[i];
         if (insert) begin
            if (prev_ahead[i]) begin
               score_in[i] = prev_score[i];
               slot_in[i]  = prev_slot[i];
            end else if (goes_ahead[i]) begin
               score_in[i] = q_entry.score;
               slot_in[i]  = SLOT_W'(count_ff);
            end
         end else if (shift) begin
            score_in[i] = next_score[i];
            slot_in[i]  = next_slot[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROW_ITEMS; i++) begin
         score_ff[i] <= score_in[i];
         slot_ff[i]  <= slot_in[i];
      end
   end

   // Sequencer: load a row, then walk the sorted cells and report.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      lim_in     = lim_ff;
      sent_in    = sent_ff;
      q_pop      = 1'b0;
      insert     = 1'b0;
      shift      = 1'b0;
      emit       = 1'b0;
      emit_index = '0;
      emit_has   = 1'b0;
      emit_done  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.wr) begin
                  insert   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (q_entry.last) begin
                  lim_in   = report_count(index_limit, count_in);
                  sent_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (lim_ff == '0) begin
               // Nothing qualifies: one empty end marker.
               if (out_free) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
                  state_in  = ST_LOAD;
                  count_in  = '0;
               end
            end else if (CNT_W'(slot_ff[0]) < lim_ff) begin
               if (out_free) begin
                  emit       = 1'b1;
                  shift      = 1'b1;
                  emit_index = IDX_W'(slot_ff[0]);
                  emit_has   = 1'b1;
                  sent_in    = sent_ff + CNT_W'(1);
                  if (sent_in == lim_ff) begin
                     emit_done = 1'b1;
                     state_in  = ST_LOAD;
                     count_in  = '0;
                  end
               end
            end else begin
               // Head is outside the report range: drop it.
               shift = 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         lim_ff   <= '0;
         sent_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lim_ff   <= lim_in;
         sent_ff  <= sent_in;
      end
   end

   // Result register: holds a word until the receiver takes it.
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= emit_index;
         rsp_has_ff   <= emit_has;
         rsp_done_ff  <= emit_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_index = rsp_index_ff;
   assign rsp_has_index  = rsp_has_ff;
   assign rsp_row_done   = rsp_done_ff;

endmodule

### sv/rank_order_of_leading_items.sv
// ----------------------------------------------------------------------------
// Rank order of leading items
// Ranks one row of scores, highest first with ties to the lower index, and
// reports the indices below a programmable limit in rank order.
//
// Usage:
//   The req channel carries one signed score word per item; req_row_last
//   marks the final word of a row. Item index is the position in the row.
//   Up to 64 scores are kept per row; later words of the row are dropped.
//   The rsp channel returns one word per reported index, row_done on the
//   last; a row with nothing to report returns one word with has_index 0.
//   The csr channel writes index_limit (reset value 2); users must do so only while the block idles (not enforced).
// Timing:
//   Scores are sorted as they arrive, one word per cycle while the back
//   loads and the four-word queue is not full; after the row end the sorted
//   cells shift out one per cycle, heads at or above the limit dropped and
//   the rest reported while the result register is free. The back takes no
//   new word until its row is reported; meanwhile the queue holds up to four.
// Reset and stalls:
//   Reset clears the row, the queue and the result register. While rsp_stall
//   is high the result word holds, reporting pauses, and once the queue fills
//   req_stall rises.
// ----------------------------------------------------------------------------
module rank_order_of_leading_items
   import roli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic                      req_row_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_item_index,
   output logic                      rsp_has_index,
   output logic                      rsp_row_done,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LIM_W-1:0]          csr_index_limit
);

   logic [LIM_W-1:0] limit_ff;
   logic [LIM_W-1:0] limit_in;
   logic             q_full;
   logic             q_push;
   entry_type        q_push_entry;
   logic             q_pop;
   logic             q_valid;
   entry_type        q_pop_entry;

   // Limit register, always writable.
   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_index_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_W'(INDEX_LIMIT_RESET);
      end else begin
         limit_ff <= limit_in;
      end
   end

   roli_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_score    (req_score),
      .req_row_last (req_row_last),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_push_entry)
   );

   roli_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_pop_entry)
   );

   roli_back u_back (
      .clock          (clock),
      .reset          (reset),
      .index_limit    (limit_ff),
      .q_valid        (q_valid),
      .q_entry        (q_pop_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item_index (rsp_item_index),
      .rsp_has_index  (rsp_has_index),
      .rsp_row_done   (rsp_row_done)
   );

endmodule

### sv/roli_checker.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: port checker
// Watches the top-level ports for result channel and end marker rules.
// ----------------------------------------------------------------------------
`include "rank_order_of_leading_items_defines.svh"

module roli_checker
   import roli_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [IDX_W-1:0] rsp_item_index,
   input logic             rsp_has_index,
   input logic             rsp_row_done
);

   // A stalled result word stays valid and unchanged.
   `ROLI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_item_index) && $stable(rsp_has_index)
         && $stable(rsp_row_done),
      "result word changed under stall")

   // An empty end marker closes its row and carries index zero.
   `ROLI_ASSERT_IMP(a_marker, clock, reset, rsp_valid && !rsp_has_index,
      rsp_row_done && (rsp_item_index == '0), "malformed empty row marker")

   // No result is presented right after reset.
   `ROLI_ASSERT_NXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind rank_order_of_leading_items roli_checker u_roli_checker (.*);

### test/rank_order_of_leading_items_tb.sv
// ----------------------------------------------------------------------------
// Rank order of leading items: testbench
// Feeds rows of signed scores through the req channel and checks every rsp
// word against a ranking predictor that keeps its own copy of the row and the
// index limit. A short table of directed rows comes first, then random rows
// in phases with a new index limit each, under random gaps and stalls and
// one long result hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module rank_order_of_leading_items_tb;
   import roli_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 350;
   localparam int PHASE_ITEMS  = 50;
   localparam int IDLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_OFF     = 300;
   localparam int CYCLE_LIMIT  = 400000;

   // One result word as the rsp channel carries it.
   typedef struct packed {
      logic [IDX_W-1:0] item_index;
      logic             has_index;
      logic             row_done;
   } rank_word_type;

   // One directed score word, with an optional limit write before it.
   typedef struct {
      bit                        set_limit;
      logic [LIM_W-1:0]          limit;
      logic signed [SCORE_W-1:0] score;
      bit                        last;
      bit                        typed;
      rank_word_type             typed_word;
   } plan_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [SCORE_W-1:0] req_score = '0;
   logic                      req_row_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [IDX_W-1:0]          rsp_item_index;
   logic                      rsp_has_index;
   logic                      rsp_row_done;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [LIM_W-1:0]          csr_index_limit = '0;

   // Predictor state: scores of the open row, their count and the limit.
   logic signed [SCORE_W-1:0] row_scores [ROW_ITEMS];
   int unsigned               row_fill = 0;
   logic [LIM_W-1:0]          index_limit_q = LIM_W'(INDEX_LIMIT_RESET);

   rank_word_type  pending_ranks[$];
   plan_word_type  plan[$];
   int             error_count = 0;
   int             cycle_count = 0;
   logic           pressure_armed = 1'b0;
   bit             pressure_done = 1'b0;
   int             hold_left = 0;
   int             stall_left = 0;
   int             run_left = 0;

   rank_order_of_leading_items u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score       (req_score),
      .req_row_last    (req_row_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_index  (rsp_item_index),
      .rsp_has_index   (rsp_has_index),
      .rsp_row_done    (rsp_row_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index_limit (csr_index_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Scores lean toward extremes and a narrow band so that ties are common.
   function automatic logic signed [SCORE_W-1:0] pick_score();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      if (r < 4) return SCORE_W'($signed($urandom_range(0, 4)) - 2);
      return SCORE_W'($urandom);
   endfunction

   // Mostly short rows, some medium, a few near or past the row capacity.
   function automatic int pick_row_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 30);
      return $urandom_range(60, 70);
   endfunction

   // True if item a ranks ahead of item b: higher score, ties to lower index.
   function automatic bit ranks_ahead(input int unsigned a, input int unsigned b);
      if (row_scores[a] != row_scores[b]) return row_scores[a] > row_scores[b];
      return a < b;
   endfunction

   // Stores one word of the row; at the row end ranks the leading items and
   // queues their indices unless the row's result is typed into the plan.
   function automatic void rank_word(input logic signed [SCORE_W-1:0] score,
                                     input bit last, input bit typed);
      int unsigned   picked [MAX_REPORT];
      int unsigned   lim;
      int unsigned   n;
      int unsigned   k;
      rank_word_type w;
      n = 0;
      if (row_fill < ROW_ITEMS) begin
         row_scores[row_fill] = score;
         row_fill++;
      end
      if (!last) return;
      lim = index_limit_q;
      if (lim > MAX_REPORT) lim = MAX_REPORT;
      if (lim > row_fill) lim = row_fill;
      // Insertion sort of the qualifying indices into rank order.
      for (int unsigned i = 0; i < lim; i++) begin
         k = n;
         while (k > 0 && ranks_ahead(i, picked[k-1])) begin
            picked[k] = picked[k-1];
            k--;
         end
         picked[k] = i;
         n++;
      end
      row_fill = 0;
      if (typed) return;
      if (n == 0) begin
         w.item_index = '0;
         w.has_index  = 1'b0;
         w.row_done   = 1'b1;
         pending_ranks.push_back(w);
      end
      for (int unsigned j = 0; j < n; j++) begin
         w.item_index = IDX_W'(picked[j]);
         w.has_index  = 1'b1;
         w.row_done   = (j + 1 == n);
         pending_ranks.push_back(w);
      end
   endfunction

   // Offers one score word until it is taken, then idles for the given gap.
   task automatic send_word(input logic signed [SCORE_W-1:0] score, input bit last,
                            input int gap, input bit typed, input rank_word_type typed_word);
      req_valid    <= 1'b1;
      req_score    <= score;
      req_row_last <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      rank_word(score, last, typed);
      if (last && typed) pending_ranks.push_back(typed_word);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every expected word has come and the block has settled.
   task automatic wait_idle();
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIM_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_index_limit <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid     <= 1'b0;
      index_limit_q = value;
   endtask

   task automatic plan_word(input bit set_limit, input int limit, input int score,
                            input bit last, input bit typed, input int idx,
                            input bit has);
      plan_word_type p;
      p.set_limit             = set_limit;
      p.limit                 = LIM_W'(limit);
      p.score                 = SCORE_W'(score);
      p.last                  = last;
      p.typed                 = typed;
      p.typed_word.item_index = IDX_W'(idx);
      p.typed_word.has_index  = has;
      p.typed_word.row_done   = 1'b1;
      plan.push_back(p);
   endtask

   // Result stall: random gaps and runs, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (pressure_armed && !pressure_done) begin
         pressure_done = 1'b1;
         hold_left     = HOLD_OFF - 1;
         rsp_stall    <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left != 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         run_left   = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 20);
         stall_left = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // Result checker: each taken word against the oldest expectation.
   always @(posedge clock) begin
      rank_word_type got;
      rank_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.item_index = rsp_item_index;
         got.has_index  = rsp_has_index;
         got.row_done   = rsp_row_done;
         if (pending_ranks.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected word, expected none, actual index %0d has %0b done %0b",
                     $time, got.item_index, got.has_index, got.row_done);
         end else begin
            want = pending_ranks.pop_front();
            if (got !== want) begin
               error_count++;
               $display(
                  "%0t ns: expected index %0d has %0b done %0b, actual index %0d has %0b done %0b",
                  $time, want.item_index, want.has_index, want.row_done,
                  got.item_index, got.has_index, got.row_done);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d words outstanding", $time, pending_ranks.size());
         $display("** rank_order_of_leading_items: FAILED **");
         $finish;
      end
   end

   // Stimulus.
   initial begin : stimulus
      int            gap;
      int            row_len;
      int            sent;
      int            phase_sent;
      int            phase;
      int            row;
      int            lim;
      bit            quiet;
      bit            row_ends_phase;
      rank_word_type none;

      none = '0;
      sent = 0;
      phase = 0;

      // Directed rows. Typed results are single words readable at a glance.
      plan_word(0, 0, 32767, 1, 1, 0, 1);        // reset limit, one item
      plan_word(0, 0, -32768, 0, 0, 0, 0);       // both extremes
      plan_word(0, 0, 32767, 1, 0, 0, 0);
      plan_word(0, 0, 100, 0, 0, 0, 0);          // tie goes to lower index
      plan_word(0, 0, 100, 1, 0, 0, 0);
      plan_word(1, 0, 5, 1, 1, 0, 0);            // nothing qualifies
      plan_word(1, 64, 1, 0, 0, 0, 0);
      plan_word(0, 0, -1, 0, 0, 0, 0);
      plan_word(0, 0, 0, 0, 0, 0, 0);
      plan_word(0, 0, 1, 1, 0, 0, 0);
      plan_word(1, 127, -1, 1, 1, 0, 1);         // limit above sixty-four
      plan_word(1, 1, -5, 0, 0, 0, 0);
      plan_word(0, 0, 7, 1, 1, 0, 1);            // only index zero reported
      plan_word(1, 3, -32768, 0, 0, 0, 0);       // three-way tie
      plan_word(0, 0, -32768, 0, 0, 0, 0);
      plan_word(0, 0, -32768, 1, 0, 0, 0);
      plan_word(1, 2, 10, 0, 0, 0, 0);           // index past the limit ranks high
      plan_word(0, 0, 20, 0, 0, 0, 0);
      plan_word(0, 0, 30, 1, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].set_limit) begin
            wait_idle();
            write_limit(plan[i].limit);
         end
         gap = pick_gap();
         if ((i + 1 == plan.size() || plan[i+1].set_limit) && gap == 0) gap = 1;
         send_word(plan[i].score, plan[i].last, gap, plan[i].typed, plan[i].typed_word);
      end

      // Random phases, each under its own index limit.
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: lim = 64;
            1: lim = 0;
            2: lim = 127;
            3: lim = 1;
            4: lim = 65;
            default: lim = $urandom_range(0, 127);
         endcase
         write_limit(LIM_W'(lim));
         phase_sent = 0;
         row = 0;
         row_ends_phase = 0;
         while (!row_ends_phase) begin
            // A full row with no gaps opens the first phase, for the hold-off.
            if (phase == 0 && row == 0) row_len = ROW_ITEMS;
            else if (phase == 0 && row == 1) row_len = 24;
            else if (phase == 2 && row == 0) row_len = ROW_ITEMS + 3;
            else row_len = pick_row_len();
            quiet = (phase == 0 && row < 2) || ($urandom_range(0, 3) == 0);
            row_ends_phase = (phase_sent + row_len >= PHASE_ITEMS) ||
                             (sent + row_len >= RANDOM_ITEMS);
            for (int w = 0; w < row_len; w++) begin
               gap = quiet ? 0 : pick_gap();
               if (w + 1 == row_len && row_ends_phase && gap == 0) gap = 1;
               send_word(pick_score(), w + 1 == row_len, gap, 1'b0, none);
               if (phase == 0 && row == 0 && w + 1 == row_len) pressure_armed <= 1'b1;
            end
            if (row_len > ROW_ITEMS) row_len = ROW_ITEMS;
            phase_sent += row_len;
            sent += row_len;
            row++;
         end
         phase++;
      end

      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** rank_order_of_leading_items: PASSED **");
      end else begin
         $display("** rank_order_of_leading_items: FAILED **");
      end
      $finish;
   end

endmodule
